// File: sv/tdpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdpf_pkg
// Shared constants and types for the TCP destination port drop filter.
// ----------------------------------------------------------------------------
package tdpf_pkg;

   // header layout, in bytes from the start of the ethernet frame
   localparam int unsigned ETH_HDR_BYTES  = 14;
   localparam int unsigned TCP_HDR_BYTES  = 20;
   localparam int unsigned ETYPE_HI_POS   = 12;
   localparam int unsigned ETYPE_LO_POS   = 13;
   localparam int unsigned IHL_POS        = ETH_HDR_BYTES;
   localparam int unsigned PROTO_POS      = ETH_HDR_BYTES + 9;
   localparam int unsigned PORT_OFFSET    = 2;

   // field values
   localparam logic [15:0] IPV4_TYPE = 16'h0800;
   localparam logic [3:0]  MIN_IHL   = 4'd5;
   localparam logic [7:0]  TCP_PROTO = 8'd6;

   // byte position counter
   localparam int unsigned POS_W   = 7;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  CSR_IDX_BLOCKED_PORT = 1'b0;

   // verdict queue depth between parser and output stage
   localparam int unsigned QUEUE_DEPTH = 2;

   // verdict transfer from parser into the queue
   typedef struct packed {
      logic push;
      logic drop;
   } verdict_type;

   // queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage : tdpf_pkg
`default_nettype wire

// File: sv/tdpf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdpf_parser
// Front part: takes one frame byte per cycle while the verdict queue has room,
// captures header fields and forms the verdict on the last byte of each frame.
// ----------------------------------------------------------------------------
module tdpf_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   input  wire logic [15:0]          blocked_port,
   input  wire tdpf_pkg::queue_status_type queue_status,
   output tdpf_pkg::verdict_type     verdict
);

   localparam int unsigned W8 = 8;

   logic [tdpf_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] port_ff, port_in;

   logic        accept;
   logic [W8-1:0] pos_ext;
   logic [W8-1:0] port_at;
   logic [W8-1:0] frame_len;
   logic [W8-1:0] need_len;
   logic        drop;

   // hold off bytes while no verdict slot is free
   assign req_stall = queue_status.full;
   assign accept    = req_valid & ~req_stall;

   assign pos_ext = W8'(pos_ff);
   assign port_at = W8'(tdpf_pkg::ETH_HDR_BYTES + tdpf_pkg::PORT_OFFSET)
                    + {2'b00, ihl_ff, 2'b00};

   // header field capture for the current byte
   always_comb begin
      ether_type_in = ether_type_ff;
      ihl_in        = ihl_ff;
      proto_in      = proto_ff;
      port_in       = port_ff;
      if (pos_ext == W8'(tdpf_pkg::ETYPE_HI_POS)) begin
         ether_type_in[15:8] = req_data_byte;
      end else if (pos_ext == W8'(tdpf_pkg::ETYPE_LO_POS)) begin
         ether_type_in[7:0] = req_data_byte;
      end else if (pos_ext == W8'(tdpf_pkg::IHL_POS)) begin
         ihl_in = req_data_byte[3:0];
      end else if (pos_ext == W8'(tdpf_pkg::PROTO_POS)) begin
         proto_in = req_data_byte;
      end
      if (pos_ext == port_at) begin
         port_in[15:8] = req_data_byte;
      end else if (pos_ext == port_at + W8'(1)) begin
         port_in[7:0] = req_data_byte;
      end
   end

   // verdict from the fields as they stand after this byte
   assign frame_len = pos_ext + W8'(1);
   assign need_len  = W8'(tdpf_pkg::ETH_HDR_BYTES + tdpf_pkg::TCP_HDR_BYTES)
                      + {2'b00, ihl_in, 2'b00};
   assign drop = (ether_type_in == tdpf_pkg::IPV4_TYPE)
              && (ihl_in >= tdpf_pkg::MIN_IHL)
              && (frame_len >= need_len)
              && (proto_in == tdpf_pkg::TCP_PROTO)
              && (port_in == blocked_port);

   // saturating byte position
   always_comb begin
      pos_in = pos_ff;
      if (pos_ff != tdpf_pkg::POS_MAX) begin
         pos_in = pos_ff + tdpf_pkg::POS_W'(1);
      end
   end

   always_comb begin
      verdict.push = accept & req_last_byte;
      verdict.drop = drop;
   end

   // frame state, cleared at the end of each frame
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         ether_type_ff <= '0;
         ihl_ff        <= '0;
         proto_ff      <= '0;
         port_ff       <= '0;
      end else if (accept) begin
         if (req_last_byte) begin
            pos_ff        <= '0;
            ether_type_ff <= '0;
            ihl_ff        <= '0;
            proto_ff      <= '0;
            port_ff       <= '0;
         end else begin
            pos_ff        <= pos_in;
            ether_type_ff <= ether_type_in;
            ihl_ff        <= ihl_in;
            proto_ff      <= proto_in;
            port_ff       <= port_in;
         end
      end
   end

   // a finished frame restarts at byte zero
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> (pos_ff == '0 && ihl_ff == '0))
      else $error("parser state not cleared after frame end");

   // position holds once saturated
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last_byte && pos_ff == tdpf_pkg::POS_MAX)
      |=> (pos_ff == tdpf_pkg::POS_MAX))
      else $error("byte position wrapped");

endmodule : tdpf_parser
`default_nettype wire

// File: sv/tdpf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdpf_queue
// Short verdict queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module tdpf_queue #(
   parameter int unsigned DEPTH = tdpf_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tdpf_pkg::verdict_type verdict,
   input  wire logic                  pop,
   output logic                       pop_drop,
   output tdpf_pkg::queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic             mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop_ok;

   assign push   = verdict.push & ~status.full;
   assign pop_ok = pop & ~status.empty;

   always_comb begin
      status.full  = (count_ff == CNT_W'(DEPTH));
      status.empty = (count_ff == '0);
   end

   assign pop_drop = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= verdict.drop;
      end
   end

   // parser never offers a verdict into a full queue
   assert property (@(posedge clock) disable iff (reset)
      verdict.push |-> !status.full)
      else $error("verdict pushed into full queue");

   // pops only come from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

endmodule : tdpf_queue
`default_nettype wire

// File: sv/tdpf_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdpf_out_stage
// Back part: moves verdicts from the queue into the result register and
// presents them on the result channel.
// ----------------------------------------------------------------------------
module tdpf_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tdpf_pkg::queue_status_type queue_status,
   input  wire logic                  queue_drop,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_drop
);

   logic rsp_valid_ff;
   logic rsp_drop_ff;

   // refill the result register when it is empty or being taken
   assign queue_pop = ~queue_status.empty & (~rsp_valid_ff | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (queue_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rsp_drop_ff <= queue_drop;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drop  = rsp_drop_ff;

   // a loaded verdict is always presented next cycle
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> rsp_valid_ff)
      else $error("loaded verdict not presented");

endmodule : tdpf_out_stage
`default_nettype wire

// File: sv/tcp_dest_port_drop_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_dest_port_drop_filter_core
// IPv4 TCP destination port filter with a one-register APB-style port.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock (starting at the ethernet
// destination address) and gives one verdict per frame. The verdict is
// written into the verdict queue and then loaded into the result register
// before it is presented on the result channel; rsp_stall can hold it. drop
// is 1 when the frame is IPv4 (ethertype 0x0800) with ihl of 5 or more,
// long enough for the whole IP header and a 20-byte TCP header, carries
// protocol 6, and has a TCP destination port equal to blocked_port
// (register 0, byte address 0). Header capture and the verdict are
// combinational in the parser, so the sustained rate is one byte per cycle;
// req_stall rises only when the verdict queue is full because the result
// side is stalled.
// ----------------------------------------------------------------------------
module tcp_dest_port_drop_filter_core #(
   parameter int unsigned QUEUE_DEPTH = tdpf_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // byte input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_last_byte,
   // verdict output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_drop,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tdpf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [tdpf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tdpf_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   logic [15:0]                   blocked_port_ff;
   logic [0:0]                    csr_index;
   logic                          csr_write;
   tdpf_pkg::verdict_type         verdict;
   tdpf_pkg::queue_status_type    queue_status;
   logic                          queue_pop;
   logic                          queue_drop;

   // register access decode
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[tdpf_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_port_ff <= '0;
      end else if (csr_write && csr_index == tdpf_pkg::CSR_IDX_BLOCKED_PORT) begin
         blocked_port_ff <= csr_pwdata[15:0];
      end
   end

   // register read mux
   always_comb begin
      case (csr_index)
         tdpf_pkg::CSR_IDX_BLOCKED_PORT: begin
            csr_prdata = {(tdpf_pkg::CSR_DATA_W - 16)'(0), blocked_port_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // front: header parse and verdict
   tdpf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .blocked_port  (blocked_port_ff),
      .queue_status  (queue_status),
      .verdict       (verdict)
   );

   // verdict queue
   tdpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .verdict  (verdict),
      .pop      (queue_pop),
      .pop_drop (queue_drop),
      .status   (queue_status)
   );

   // back: result register
   tdpf_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_drop   (queue_drop),
      .queue_pop    (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drop     (rsp_drop)
   );

endmodule : tcp_dest_port_drop_filter_core
`default_nettype wire
